/* hdl/ael_pkg.sv */
// Shared types, token codes and keyword trie for the expression lexer.
`timescale 1ns / 1ps

package ael_pkg;

  localparam logic [2:0] KIND_OP      = 3'd0;
  localparam logic [2:0] KIND_NUM     = 3'd1;
  localparam logic [2:0] KIND_CONST   = 3'd2;
  localparam logic [2:0] KIND_BRACKET = 3'd3;
  localparam logic [2:0] KIND_FUNC    = 3'd4;
  localparam logic [2:0] KIND_COMMA   = 3'd5;
  localparam logic [2:0] KIND_ERR     = 3'd6;

  localparam logic [3:0] NO_CODE = 4'd0;

  localparam logic [3:0] OP_ADD = 4'd0;
  localparam logic [3:0] OP_SUB = 4'd1;
  localparam logic [3:0] OP_MUL = 4'd2;
  localparam logic [3:0] OP_DIV = 4'd3;
  localparam logic [3:0] OP_POW = 4'd4;

  localparam logic [3:0] BR_PAREN_L  = 4'd0;
  localparam logic [3:0] BR_PAREN_R  = 4'd1;
  localparam logic [3:0] BR_SQUARE_L = 4'd2;
  localparam logic [3:0] BR_SQUARE_R = 4'd3;
  localparam logic [3:0] BR_CURLY_L  = 4'd4;
  localparam logic [3:0] BR_CURLY_R  = 4'd5;
  localparam logic [3:0] BR_BAR      = 4'd6;

  localparam logic [3:0] ERR_SECOND_DOT = 4'd0;
  localparam logic [3:0] ERR_LONE_DOT   = 4'd1;
  localparam logic [3:0] ERR_BAD_CHAR   = 4'd2;
  localparam logic [3:0] ERR_BAD_NAME   = 4'd3;

  localparam logic [3:0] CONST_PI = 4'd0;
  localparam logic [3:0] CONST_E  = 4'd1;

  localparam logic [3:0] FN_SIN  = 4'd0;
  localparam logic [3:0] FN_COS  = 4'd1;
  localparam logic [3:0] FN_TG   = 4'd2;
  localparam logic [3:0] FN_CTG  = 4'd3;
  localparam logic [3:0] FN_ASIN = 4'd4;
  localparam logic [3:0] FN_ACOS = 4'd5;
  localparam logic [3:0] FN_ATG  = 4'd6;
  localparam logic [3:0] FN_ACTG = 4'd7;
  localparam logic [3:0] FN_LN   = 4'd8;
  localparam logic [3:0] FN_LG   = 4'd9;
  localparam logic [3:0] FN_LOG  = 4'd10;

  localparam logic [4:0] NODE_ROOT = 5'd0;

  typedef struct packed {
    logic [2:0]  kind;
    logic [3:0]  code;
    logic [31:0] mantissa;
    logic [5:0]  frac;
    logic        ovf;
    logic [15:0] pos;
    logic        last;
  } tok_t;

  typedef struct packed {
    logic       hit;
    logic       done;
    logic [4:0] to;
    logic [2:0] kind;
    logic [3:0] code;
  } trie_t;

  function automatic tok_t mk_tok(input logic [2:0] kind, input logic [3:0] code,
                                  input logic [15:0] pos);
    tok_t t;
    t          = '0;
    t.kind     = kind;
    t.code     = code;
    t.pos      = pos;
    return t;
  endfunction

  function automatic trie_t part_edge(input logic [4:0] to);
    trie_t r;
    r     = '0;
    r.hit = 1'b1;
    r.to  = to;
    return r;
  endfunction

  function automatic trie_t full_edge(input logic [2:0] kind, input logic [3:0] code);
    trie_t r;
    r      = '0;
    r.hit  = 1'b1;
    r.done = 1'b1;
    r.kind = kind;
    r.code = code;
    return r;
  endfunction

  // One step through the name trie: PI and the eleven function names.
  function automatic trie_t trie_step(input logic [4:0] node, input logic [7:0] c);
    trie_t r;
    r = '0;
    case (node)
      5'd0: begin
        if (c == "P") r = part_edge(5'd1);
        else if (c == "s") r = part_edge(5'd2);
        else if (c == "c") r = part_edge(5'd4);
        else if (c == "t") r = part_edge(5'd7);
        else if (c == "a") r = part_edge(5'd8);
        else if (c == "l") r = part_edge(5'd15);
      end
      5'd1:  if (c == "I") r = full_edge(KIND_CONST, CONST_PI);
      5'd2:  if (c == "i") r = part_edge(5'd3);
      5'd3:  if (c == "n") r = full_edge(KIND_FUNC, FN_SIN);
      5'd4: begin
        if (c == "o") r = part_edge(5'd5);
        else if (c == "t") r = part_edge(5'd6);
      end
      5'd5:  if (c == "s") r = full_edge(KIND_FUNC, FN_COS);
      5'd6:  if (c == "g") r = full_edge(KIND_FUNC, FN_CTG);
      5'd7:  if (c == "g") r = full_edge(KIND_FUNC, FN_TG);
      5'd8: begin
        if (c == "s") r = part_edge(5'd9);
        else if (c == "c") r = part_edge(5'd11);
        else if (c == "t") r = part_edge(5'd14);
      end
      5'd9:  if (c == "i") r = part_edge(5'd10);
      5'd10: if (c == "n") r = full_edge(KIND_FUNC, FN_ASIN);
      5'd11: begin
        if (c == "o") r = part_edge(5'd12);
        else if (c == "t") r = part_edge(5'd13);
      end
      5'd12: if (c == "s") r = full_edge(KIND_FUNC, FN_ACOS);
      5'd13: if (c == "g") r = full_edge(KIND_FUNC, FN_ACTG);
      5'd14: if (c == "g") r = full_edge(KIND_FUNC, FN_ATG);
      5'd15: begin
        if (c == "n") r = full_edge(KIND_FUNC, FN_LN);
        else if (c == "g") r = full_edge(KIND_FUNC, FN_LG);
        else if (c == "o") r = part_edge(5'd16);
      end
      5'd16: if (c == "g") r = full_edge(KIND_FUNC, FN_LOG);
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

/* hdl/ael_if.sv */
// Valid/ready channel interfaces for characters in and tokens out.
`timescale 1ns / 1ps

interface ael_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       end_of_text;

  modport source (output valid, output char_code, output end_of_text, input ready);
  modport sink   (input valid, input char_code, input end_of_text, output ready);
endinterface

interface ael_token_if;
  logic        valid;
  logic        ready;
  logic [2:0]  token_kind;
  logic [3:0]  token_code;
  logic [31:0] mantissa;
  logic [5:0]  fraction_digits;
  logic        number_overflow;
  logic [15:0] token_position;
  logic        last_of_run;

  modport source (output valid, output token_kind, output token_code, output mantissa,
                  output fraction_digits, output number_overflow, output token_position,
                  output last_of_run, input ready);
  modport sink   (input valid, input token_kind, input token_code, input mantissa,
                  input fraction_digits, input number_overflow, input token_position,
                  input last_of_run, output ready);
endinterface

/* hdl/arithmetic_expression_lexer_top.sv */
// Top level of the streaming arithmetic expression lexer.
//
//   channel  direction  transaction
//   char_i   in         one character plus end_of_text flag
//   tok_o    out        one token (operator, number, name, bracket, comma, error)
//
// One character is taken per cycle while char_i.ready is high; its tokens (zero, one
// or two) are computed in the same cycle from the scan state and written into a 4-entry
// token queue, from which tok_o offers them in order after any older queued tokens.
// char_i.ready is high while at most two tokens wait, so a stalled tok_o stops
// input once three or more tokens are queued.
// Reset clears the scan state and empties the queue; no clearing pass is needed.
`timescale 1ns / 1ps

module arithmetic_expression_lexer_top
  import ael_pkg::*;
#(
  parameter int MANTISSA_BITS = 32,
  parameter int POSITION_BITS = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  ael_char_if.sink     char_i,
  ael_token_if.source  tok_o
);

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_NUM  = 2'd1,
    MODE_KEY  = 2'd2,
    MODE_DROP = 2'd3
  } mode_e;

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  mode_e                    mode_q, mode_d;
  logic [4:0]               node_q, node_d;
  logic [MANTISSA_BITS-1:0] acc_q, acc_d;
  logic [5:0]               frac_q, frac_d;
  logic                     dot_q, dot_d;
  logic                     sat_q, sat_d;
  logic [POSITION_BITS-1:0] idx_q, idx_d;
  logic [POSITION_BITS-1:0] start_q, start_d;

  tok_t                     q_mem_q [QDEPTH];
  logic [QAW-1:0]           wp_q, rp_q;
  logic [QAW:0]             cnt_q;

  tok_t                     res0, res1;
  logic [1:0]               n_res;
  logic                     in_fire, out_fire;

  function automatic logic [31:0] mant32(input logic [MANTISSA_BITS-1:0] a);
    logic [MANTISSA_BITS+31:0] e;
    e = {32'd0, a};
    return e[31:0];
  endfunction

  function automatic logic [15:0] pos16(input logic [POSITION_BITS-1:0] p);
    logic [POSITION_BITS+15:0] e;
    e = {16'd0, p};
    return e[15:0];
  endfunction

  assign in_fire  = char_i.valid && char_i.ready;
  assign out_fire = tok_o.valid && tok_o.ready;

  // Scan step: phase A per mode, phase B idle character, phase C end of text.
  always_comb begin
    logic [7:0]               c;
    logic                     is_digit;
    logic [3:0]               dig;
    logic [MANTISSA_BITS+3:0] accx, prod;
    logic                     do_idle;
    trie_t                    tr;
    tok_t                     ta, tb, tc, num;
    logic                     va, vb, vc;

    c        = char_i.char_code;
    is_digit = (c >= "0") && (c <= "9");
    dig      = c[3:0];
    accx     = {4'd0, acc_q};
    prod     = (accx << 3) + (accx << 1) + {{MANTISSA_BITS{1'b0}}, dig};
    do_idle  = 1'b0;
    ta = '0; tb = '0; tc = '0; num = '0;
    va = 1'b0; vb = 1'b0; vc = 1'b0;
    tr = '0;

    mode_d  = mode_q;
    node_d  = node_q;
    acc_d   = acc_q;
    frac_d  = frac_q;
    dot_d   = dot_q;
    sat_d   = sat_q;
    start_d = start_q;

    case (mode_q)
      MODE_NUM: begin
        if (is_digit) begin
          if (sat_q || (|prod[MANTISSA_BITS+3:MANTISSA_BITS])) begin
            acc_d = '1;
            sat_d = 1'b1;
          end else begin
            acc_d = prod[MANTISSA_BITS-1:0];
          end
          if (dot_q && frac_q < 6'd63) frac_d = frac_q + 6'd1;
          node_d = 5'd1;
        end else if (c == ".") begin
          if (dot_q) begin
            ta     = mk_tok(KIND_ERR, ERR_SECOND_DOT, pos16(start_q));
            va     = 1'b1;
            mode_d = MODE_DROP;
            node_d = NODE_ROOT;
          end else begin
            dot_d = 1'b1;
          end
        end else begin
          if (!node_q[0]) begin
            ta     = mk_tok(KIND_ERR, ERR_LONE_DOT, pos16(start_q));
            mode_d = MODE_DROP;
          end else begin
            ta          = mk_tok(KIND_NUM, NO_CODE, pos16(start_q));
            ta.mantissa = mant32(acc_q);
            ta.frac     = frac_q;
            ta.ovf      = sat_q;
            mode_d      = MODE_IDLE;
            do_idle     = 1'b1;
          end
          va     = 1'b1;
          node_d = NODE_ROOT;
        end
      end
      MODE_KEY: begin
        tr = trie_step(node_q, c);
        if (tr.hit && tr.done) begin
          ta     = mk_tok(tr.kind, tr.code, pos16(start_q));
          va     = 1'b1;
          mode_d = MODE_IDLE;
          node_d = NODE_ROOT;
        end else if (tr.hit) begin
          node_d = tr.to;
        end else begin
          ta     = mk_tok(KIND_ERR, ERR_BAD_NAME, pos16(start_q));
          va     = 1'b1;
          mode_d = MODE_DROP;
          node_d = NODE_ROOT;
        end
      end
      MODE_IDLE: do_idle = 1'b1;
      default:   do_idle = 1'b0;
    endcase

    if (do_idle) begin
      tr = trie_step(NODE_ROOT, c);
      if (c == " " || c == 8'h09) begin
        vb = 1'b0;
      end else if (c == "+" || c == "-" || c == "*" || c == "/" || c == "^") begin
        vb = 1'b1;
        case (c)
          "+":     tb = mk_tok(KIND_OP, OP_ADD, pos16(idx_q));
          "-":     tb = mk_tok(KIND_OP, OP_SUB, pos16(idx_q));
          "*":     tb = mk_tok(KIND_OP, OP_MUL, pos16(idx_q));
          "/":     tb = mk_tok(KIND_OP, OP_DIV, pos16(idx_q));
          default: tb = mk_tok(KIND_OP, OP_POW, pos16(idx_q));
        endcase
      end else if (is_digit || c == ".") begin
        mode_d  = MODE_NUM;
        start_d = idx_q;
        frac_d  = 6'd0;
        sat_d   = 1'b0;
        if (is_digit) begin
          acc_d  = {{(MANTISSA_BITS-4){1'b0}}, dig};
          dot_d  = 1'b0;
          node_d = 5'd1;
        end else begin
          acc_d  = '0;
          dot_d  = 1'b1;
          node_d = NODE_ROOT;
        end
      end else if (c == "e") begin
        tb = mk_tok(KIND_CONST, CONST_E, pos16(idx_q));
        vb = 1'b1;
      end else if (c == "(" || c == ")" || c == "[" || c == "]" || c == "{" ||
                   c == "}" || c == "|") begin
        vb = 1'b1;
        case (c)
          "(":     tb = mk_tok(KIND_BRACKET, BR_PAREN_L, pos16(idx_q));
          ")":     tb = mk_tok(KIND_BRACKET, BR_PAREN_R, pos16(idx_q));
          "[":     tb = mk_tok(KIND_BRACKET, BR_SQUARE_L, pos16(idx_q));
          "]":     tb = mk_tok(KIND_BRACKET, BR_SQUARE_R, pos16(idx_q));
          "{":     tb = mk_tok(KIND_BRACKET, BR_CURLY_L, pos16(idx_q));
          "}":     tb = mk_tok(KIND_BRACKET, BR_CURLY_R, pos16(idx_q));
          default: tb = mk_tok(KIND_BRACKET, BR_BAR, pos16(idx_q));
        endcase
      end else if (tr.hit && !tr.done) begin
        mode_d  = MODE_KEY;
        node_d  = tr.to;
        start_d = idx_q;
      end else if (c == ",") begin
        tb = mk_tok(KIND_COMMA, NO_CODE, pos16(idx_q));
        vb = 1'b1;
      end else begin
        tb     = mk_tok(KIND_ERR, ERR_BAD_CHAR, pos16(idx_q));
        vb     = 1'b1;
        mode_d = MODE_DROP;
      end
    end

    if (char_i.end_of_text) begin
      if (mode_d == MODE_NUM) begin
        if (!node_d[0]) begin
          tc = mk_tok(KIND_ERR, ERR_LONE_DOT, pos16(start_d));
        end else begin
          num          = mk_tok(KIND_NUM, NO_CODE, pos16(start_d));
          num.mantissa = mant32(acc_d);
          num.frac     = frac_d;
          num.ovf      = sat_d;
          tc           = num;
        end
        vc = 1'b1;
      end else if (mode_d == MODE_KEY) begin
        tc = mk_tok(KIND_ERR, ERR_BAD_NAME, pos16(start_d));
        vc = 1'b1;
      end
      mode_d = MODE_IDLE;
      node_d = NODE_ROOT;
      acc_d  = '0;
      frac_d = 6'd0;
      dot_d  = 1'b0;
      sat_d  = 1'b0;
      idx_d  = '0;
    end else begin
      idx_d = idx_q + 1'b1;
    end

    // Keep the first two tokens in order.
    res0 = '0;
    res1 = '0;
    if (va) begin
      res0  = ta;
      res1  = vb ? tb : tc;
      n_res = (vb || vc) ? 2'd2 : 2'd1;
    end else if (vb) begin
      res0  = tb;
      res1  = tc;
      n_res = vc ? 2'd2 : 2'd1;
    end else begin
      res0  = tc;
      n_res = vc ? 2'd1 : 2'd0;
    end
    res0.last = (n_res == 2'd1);
    res1.last = (n_res == 2'd2);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_IDLE;
      node_q  <= '0;
      acc_q   <= '0;
      frac_q  <= '0;
      dot_q   <= 1'b0;
      sat_q   <= 1'b0;
      idx_q   <= '0;
      start_q <= '0;
    end else if (in_fire) begin
      mode_q  <= mode_d;
      node_q  <= node_d;
      acc_q   <= acc_d;
      frac_q  <= frac_d;
      dot_q   <= dot_d;
      sat_q   <= sat_d;
      idx_q   <= idx_d;
      start_q <= start_d;
    end
  end

  // Token queue.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (in_fire) wp_q <= wp_q + QAW'(n_res);
      if (out_fire) rp_q <= rp_q + 1'b1;
      cnt_q <= cnt_q + (in_fire ? (QAW+1)'(n_res) : '0) - (QAW+1)'(out_fire);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && n_res != 2'd0) q_mem_q[wp_q] <= res0;
    if (in_fire && n_res == 2'd2) q_mem_q[wp_q + 1'b1] <= res1;
  end

  assign char_i.ready = (cnt_q <= (QAW+1)'(QDEPTH - 2));

  assign tok_o.valid           = (cnt_q != '0);
  assign tok_o.token_kind      = q_mem_q[rp_q].kind;
  assign tok_o.token_code      = q_mem_q[rp_q].code;
  assign tok_o.mantissa        = q_mem_q[rp_q].mantissa;
  assign tok_o.fraction_digits = q_mem_q[rp_q].frac;
  assign tok_o.number_overflow = q_mem_q[rp_q].ovf;
  assign tok_o.token_position  = q_mem_q[rp_q].pos;
  assign tok_o.last_of_run     = q_mem_q[rp_q].last;

endmodule
